/* design/acia_pkg.sv */
// Shared types, access codes and helpers for the serial ACIA model core.
// No dependencies; imported by acia_step and serial_acia_model_core.
package acia_pkg;

  // Access codes carried in the action field
  typedef enum logic [2:0] {
    ACT_LINE_DELIVER = 3'd0,
    ACT_LINE_TAKE    = 3'd1,
    ACT_STATUS_READ  = 3'd2,
    ACT_CTRL_WRITE   = 3'd3,
    ACT_DATA_READ    = 3'd4,
    ACT_DATA_WRITE   = 3'd5,
    ACT_IRQ_POLL     = 3'd6
  } acia_action_t;

  // Control byte bit positions and the tx interrupt enable code
  localparam int unsigned CTRL_RX_IRQ_EN = 7;
  localparam int unsigned CTRL_RX_BLOCK  = 6;
  localparam logic [2:0]  CTRL_TX_IRQ_ALL = 3'b111;

  // Status byte bit positions
  localparam int unsigned STAT_RX_FULL  = 0;
  localparam int unsigned STAT_TX_EMPTY = 1;
  localparam int unsigned STAT_IRQ      = 7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_in;
  } acia_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raised;
    logic       line_can_send;
    logic       tx_pending;
    logic       delivery_refused;
  } acia_out_t;

  typedef struct packed {
    logic       rx_full;
    logic       tx_empty;
    logic       irq_flag;
    logic [7:0] control_byte;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
    logic       irq_in_service;
  } acia_state_t;

  // Interrupt set condition, evaluated on the updated flags and control byte
  function automatic logic irq_cond(logic rx_full, logic tx_empty, logic [7:0] ctrl);
    irq_cond = (rx_full && ctrl[CTRL_RX_IRQ_EN]) ||
               (tx_empty && (ctrl[7:5] == CTRL_TX_IRQ_ALL));
  endfunction

endpackage

/* design/acia_step.sv */
// Combinational access logic: next state and result for one access beat.
// Depends on acia_pkg.
module acia_step (
  input  acia_pkg::acia_state_t st,
  input  acia_pkg::acia_in_t    in_beat,
  output acia_pkg::acia_state_t st_nxt,
  output acia_pkg::acia_out_t   res
);
  import acia_pkg::*;

  logic [7:0] rd;
  logic       raised;
  logic       refused;
  logic [7:0] status_byte;

  always_comb begin
    status_byte = '0;
    status_byte[STAT_RX_FULL]  = st.rx_full;
    status_byte[STAT_TX_EMPTY] = st.tx_empty;
    status_byte[STAT_IRQ]      = st.irq_flag;
  end

  // Per-access state update
  always_comb begin
    st_nxt  = st;
    rd      = '0;
    raised  = 1'b0;
    refused = 1'b0;
    unique case (acia_action_t'(in_beat.action))
      ACT_LINE_DELIVER: begin
        if (st.control_byte[CTRL_RX_BLOCK]) begin
          refused = 1'b1;
        end else begin
          st_nxt.rx_full  = 1'b1;
          st_nxt.rx_byte  = in_beat.data_in;
          st_nxt.irq_flag = st.irq_flag | irq_cond(1'b1, st.tx_empty, st.control_byte);
        end
      end
      ACT_LINE_TAKE: begin
        st_nxt.tx_empty = 1'b1;
        st_nxt.irq_flag = st.irq_flag | irq_cond(st.rx_full, 1'b1, st.control_byte);
        rd = st.tx_byte;
      end
      ACT_STATUS_READ: begin
        rd = status_byte;
      end
      ACT_CTRL_WRITE: begin
        st_nxt.control_byte = in_beat.data_in;
        st_nxt.irq_flag = st.irq_flag | irq_cond(st.rx_full, st.tx_empty, in_beat.data_in);
      end
      ACT_DATA_READ: begin
        st_nxt.rx_full        = 1'b0;
        st_nxt.irq_flag       = 1'b0;
        st_nxt.irq_in_service = 1'b0;
        rd = st.rx_byte;
      end
      ACT_DATA_WRITE: begin
        // flag is cleared first, then re-evaluated with tx no longer empty
        st_nxt.tx_byte        = in_beat.data_in;
        st_nxt.tx_empty       = 1'b0;
        st_nxt.irq_in_service = 1'b0;
        st_nxt.irq_flag       = irq_cond(st.rx_full, 1'b0, st.control_byte);
      end
      ACT_IRQ_POLL: begin
        if (!st.irq_in_service) begin
          st_nxt.irq_in_service = st.irq_flag;
          raised = st.irq_flag;
        end
      end
      default: begin
        // unused code: no state change
      end
    endcase
  end

  // Result fields reflect the state after the access
  always_comb begin
    res.read_data        = rd;
    res.irq_raised       = raised;
    res.line_can_send    = !st_nxt.rx_full && !st_nxt.control_byte[CTRL_RX_BLOCK];
    res.tx_pending       = !st_nxt.tx_empty;
    res.delivery_refused = refused;
  end

endmodule

/* design/serial_acia_model_core.sv */
// Top level of the serial ACIA model: state registers, result register, handshakes.
// Depends on acia_pkg and acia_step.
//
//   channel | direction | ports                      | beat
//   --------+-----------+----------------------------+-----------------------------
//   in      | input     | in_valid, in_ready, in_data  | one access (action, data_in)
//   out     | output    | out_valid, out_ready, out_data | one result per access
//
// Flags and bytes update at the edge that accepts an access, and
// the result sits in the output register from the next cycle on.
// in_ready is high whenever the output register is empty or is being drained,
// so one access per cycle is sustained; a stalled result holds off new accesses.
// Reset (rst_n low, synchronous) restores the flag and byte reset values and
// empties the output register.
module serial_acia_model_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  acia_pkg::acia_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acia_pkg::acia_out_t out_data
);
  import acia_pkg::*;

  acia_state_t st_r, st_nxt;
  acia_out_t   res;
  acia_out_t   out_r;
  logic        out_valid_r;
  logic        in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  acia_step u_step (
    .st      (st_r),
    .in_beat (in_data),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // Adapter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.rx_full        <= 1'b0;
      st_r.tx_empty       <= 1'b1;
      st_r.irq_flag       <= 1'b0;
      st_r.control_byte   <= '0;
      st_r.rx_byte        <= '0;
      st_r.tx_byte        <= '0;
      st_r.irq_in_service <= 1'b0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low with empty result register");

  a_refuse_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.action == ACT_LINE_DELIVER) && st_r.control_byte[CTRL_RX_BLOCK]
    |=> out_r.delivery_refused && $stable(st_r))
    else $error("blocked delivery not refused or changed state");

  a_raise_in_service: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.irq_raised |-> st_r.irq_in_service)
    else $error("interrupt raised without in-service latch");

  a_flags_track_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.tx_pending == !st_r.tx_empty) &&
      (out_r.line_can_send == (!st_r.rx_full && !st_r.control_byte[CTRL_RX_BLOCK])))
    else $error("result flags disagree with held state");

endmodule
